// ----- design/ps2_mouse_packet_cursor_tracker_core_assert.svh -----
// assertion macros shared by the cursor tracker modules
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_ASSERT_SVH

// plain property checked on every edge out of reset
`define PMCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define PMCT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PMCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pmct_pkg.sv -----
// shared types and constants for the ps/2 mouse cursor tracker
// no dependencies
package pmct_pkg;

  localparam int PosBits    = 14;
  localparam int StepBits   = PosBits + 2;
  localparam int AccumBits  = 32;
  localparam int DeltaBits  = 9;
  localparam int BtnBits    = 3;
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = 32;
  localparam int QDepth     = 2;
  localparam int QPtrBits   = $clog2(QDepth);
  localparam int QCntBits   = $clog2(QDepth + 1);

  localparam logic [PosBits-1:0] WidthReset  = PosBits'(1024);
  localparam logic [PosBits-1:0] HeightReset = PosBits'(768);

  // status byte bit positions
  localparam int SyncBit  = 3;
  localparam int XSignBit = 4;
  localparam int YSignBit = 5;
  localparam int XOvfBit  = 6;
  localparam int YOvfBit  = 7;

  // register indexes
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_REJECT = 3'd1,
    OP_STATUS = 3'd2,
    OP_DX     = 3'd3,
    OP_DY     = 3'd4
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic signed [DeltaBits-1:0] delta;
    logic [BtnBits-1:0]          buttons;
  } item_t;

  typedef struct packed {
    logic               en;
    logic               idx;
    logic [PosBits-1:0] data;
  } cfg_wr_t;

endpackage

// ----- design/pmct_front.sv -----
// front end: tracks packet phase and status byte, classifies each beat
// depends on pmct_pkg
module pmct_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           from_aux,
  output pmct_pkg::item_t item
);
  import pmct_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] status_r, status_nxt;
  logic       sync_ok;
  logic       sign;

  assign sync_ok = data_byte[SyncBit] && !data_byte[XOvfBit] && !data_byte[YOvfBit];

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    if (accept && from_aux) begin
      unique case (phase_r)
        PH_DX: phase_nxt = PH_DY;
        PH_DY: phase_nxt = PH_STATUS;
        default: begin
          if (sync_ok) begin
            phase_nxt  = PH_DX;
            status_nxt = data_byte;
          end else begin
            phase_nxt = PH_STATUS;
          end
        end
      endcase
    end
  end

  // classification of the beat on the input
  always_comb begin
    item.op = OP_NONE;
    sign    = 1'b0;
    if (from_aux) begin
      unique case (phase_r)
        PH_DX: begin
          item.op = OP_DX;
          sign    = status_r[XSignBit];
        end
        PH_DY: begin
          item.op = OP_DY;
          sign    = status_r[YSignBit];
        end
        default: item.op = sync_ok ? OP_STATUS : OP_REJECT;
      endcase
    end
    item.delta   = {sign, data_byte};
    item.buttons = (item.op == OP_STATUS) ? data_byte[BtnBits-1:0]
                                          : status_r[BtnBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_STATUS;
      status_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ----- design/pmct_queue.sv -----
// short fifo of classified beats between front and back
// depends on pmct_pkg and the assertion macro header
module pmct_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pmct_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output pmct_pkg::item_t pop_item,
  output logic            not_empty
);
  import pmct_pkg::*;

  item_t                entry_r [QDepth];
  logic [QPtrBits-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCntBits-1:0]  count_r;

  assign full      = (count_r == QCntBits'(QDepth));
  assign not_empty = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`include "ps2_mouse_packet_cursor_tracker_core_assert.svh"

  `PMCT_ASSERT(a_count_bound, count_r <= QCntBits'(QDepth), "queue count past depth")
  `PMCT_ASSERT_IMPL(a_pop_nonempty, pop, not_empty, "pop from empty queue")

endmodule

// ----- design/pmct_back.sv -----
// back end: cursor and accumulator update, clamp, size registers, result register
// depends on pmct_pkg and the assertion macro header
module pmct_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pmct_pkg::cfg_wr_t                 cfg_wr,
  input  logic                              cfg_rd_idx,
  output logic [pmct_pkg::CfgDataBits-1:0]  cfg_rdata,
  input  logic                              q_valid,
  input  pmct_pkg::item_t                   q_item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pmct_pkg::PosBits-1:0]      cursor_x,
  output logic [pmct_pkg::PosBits-1:0]      cursor_y,
  output logic [pmct_pkg::AccumBits-1:0]    total_x,
  output logic [pmct_pkg::AccumBits-1:0]    total_y,
  output logic [pmct_pkg::BtnBits-1:0]      buttons,
  output logic                              packet_done,
  output logic                              sync_reject
);
  import pmct_pkg::*;

  logic [PosBits-1:0]         width_r, height_r;
  logic [PosBits-1:0]         pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [AccumBits-1:0]       accum_x_r, accum_x_nxt, accum_y_r, accum_y_nxt;
  logic [BtnBits-1:0]         btn_r;
  logic                       done_r, reject_r, valid_r;
  logic [PosBits-1:0]         lim_x, lim_y;
  logic signed [StepBits-1:0] step_x, step_y, sum_x, sum_y;
  logic [AccumBits-1:0]       delta_ext;
  logic [PosBits-1:0]         new_x, new_y;

  assign pop = q_valid && (!valid_r || out_ready);

  // size of zero behaves as one
  assign lim_x = (width_r == '0)  ? '0 : width_r - 1'b1;
  assign lim_y = (height_r == '0) ? '0 : height_r - 1'b1;

  assign step_x    = StepBits'(q_item.delta);
  assign step_y    = -StepBits'(q_item.delta);
  assign sum_x     = $signed({2'b00, pos_x_r}) + step_x;
  assign sum_y     = $signed({2'b00, pos_y_r}) + step_y;
  assign delta_ext = AccumBits'(q_item.delta);

  always_comb begin
    priority if (sum_x < 0) begin
      new_x = '0;
    end else if (sum_x > $signed({2'b00, lim_x})) begin
      new_x = lim_x;
    end else begin
      new_x = sum_x[PosBits-1:0];
    end
    priority if (sum_y < 0) begin
      new_y = '0;
    end else if (sum_y > $signed({2'b00, lim_y})) begin
      new_y = lim_y;
    end else begin
      new_y = sum_y[PosBits-1:0];
    end
  end

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    accum_x_nxt = accum_x_r;
    accum_y_nxt = accum_y_r;
    if (cfg_wr.en) begin
      // a size write re-centres both coordinates
      pos_x_nxt = (cfg_wr.idx == RegWidth)  ? (cfg_wr.data >> 1) : (width_r >> 1);
      pos_y_nxt = (cfg_wr.idx == RegHeight) ? (cfg_wr.data >> 1) : (height_r >> 1);
    end else if (pop) begin
      if (q_item.op == OP_DX) begin
        pos_x_nxt   = new_x;
        accum_x_nxt = accum_x_r + delta_ext;
      end
      if (q_item.op == OP_DY) begin
        pos_y_nxt   = new_y;
        accum_y_nxt = accum_y_r - delta_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WidthReset;
      height_r  <= HeightReset;
      pos_x_r   <= WidthReset >> 1;
      pos_y_r   <= HeightReset >> 1;
      accum_x_r <= '0;
      accum_y_r <= '0;
      btn_r     <= '0;
      done_r    <= 1'b0;
      reject_r  <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      if (cfg_wr.en && cfg_wr.idx == RegWidth) begin
        width_r <= cfg_wr.data;
      end
      if (cfg_wr.en && cfg_wr.idx == RegHeight) begin
        height_r <= cfg_wr.data;
      end
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      accum_x_r <= accum_x_nxt;
      accum_y_r <= accum_y_nxt;
      if (pop) begin
        btn_r    <= q_item.buttons;
        done_r   <= (q_item.op == OP_DY);
        reject_r <= (q_item.op == OP_REJECT);
        valid_r  <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign cfg_rdata   = CfgDataBits'((cfg_rd_idx == RegHeight) ? height_r : width_r);
  assign out_valid   = valid_r;
  assign cursor_x    = pos_x_r;
  assign cursor_y    = pos_y_r;
  assign total_x     = accum_x_r;
  assign total_y     = accum_y_r;
  assign buttons     = btn_r;
  assign packet_done = done_r;
  assign sync_reject = reject_r;

`include "ps2_mouse_packet_cursor_tracker_core_assert.svh"

  `PMCT_ASSERT(a_x_in_range, pos_x_r <= lim_x, "cursor x beyond screen width")
  `PMCT_ASSERT(a_y_in_range, pos_y_r <= lim_y, "cursor y beyond screen height")
  `PMCT_ASSERT(a_flags_excl, !(done_r && reject_r), "packet done and sync reject together")
  `PMCT_ASSERT_NEXT(a_done_follows, pop && q_item.op == OP_DY, done_r && valid_r, "missing packet done")

endmodule

// ----- design/ps2_mouse_packet_cursor_tracker_core.sv -----
// PS/2 mouse packet decoder with a clamped cursor and unclamped motion totals.
// Every input beat yields exactly one result beat. The block sustains one beat per
// clock while out_tready holds: the front end classifies a byte against the packet
// phase in the cycle it is accepted, a two-entry queue registers it for the back end,
// whose single add-and-clamp per axis updates the cursor and loads the result register
// as the entry is popped, which waits while the output stalls. Size writes over the
// register port re-centre the cursor and are meant for idle periods only.
module ps2_mouse_packet_cursor_tracker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic [0:0]                       in_tuser,   // [0] from_aux_port
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [13:0] cursor_x, [27:14] cursor_y, [59:28] total_x, [91:60] total_y,
  // [94:92] buttons, [95] zero
  output logic [95:0]                      out_tdata,
  output logic [1:0]                       out_tuser,  // [0] packet_done, [1] sync_reject
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pmct_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  logic [pmct_pkg::CfgDataBits-1:0] cfg_pwdata,
  output logic [pmct_pkg::CfgDataBits-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import pmct_pkg::*;

  item_t                fr_item, q_item;
  logic                 q_full, q_valid, pop, accept;
  cfg_wr_t              cfg_wr;
  logic [PosBits-1:0]   cursor_x, cursor_y;
  logic [AccumBits-1:0] total_x, total_y;
  logic [BtnBits-1:0]   buttons;
  logic                 packet_done, sync_reject;

  assign in_tready  = !q_full;
  assign accept     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;

  assign cfg_wr.en   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_wr.idx  = cfg_paddr[2];
  assign cfg_wr.data = cfg_pwdata[PosBits-1:0];

  pmct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .from_aux  (in_tuser[0]),
    .item      (fr_item)
  );

  pmct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (fr_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  pmct_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .cfg_rd_idx  (cfg_paddr[2]),
    .cfg_rdata   (cfg_prdata),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .cursor_x    (cursor_x),
    .cursor_y    (cursor_y),
    .total_x     (total_x),
    .total_y     (total_y),
    .buttons     (buttons),
    .packet_done (packet_done),
    .sync_reject (sync_reject)
  );

  assign out_tdata = {1'b0, buttons, total_y, total_x, cursor_y, cursor_x};
  assign out_tuser = {sync_reject, packet_done};

endmodule

// ----- verif/ps2_mouse_packet_cursor_tracker_core_test.sv -----
// self-checking testbench for ps2_mouse_packet_cursor_tracker_core: drives bytes and
// size writes, predicts every result beat with a cycle-free cursor model and compares.
// depends on pmct_pkg and the core module only
`timescale 1ns / 1ps

typedef struct {
  logic [13:0] cursor_x;
  logic [13:0] cursor_y;
  logic [31:0] total_x;
  logic [31:0] total_y;
  logic [2:0]  buttons;
  logic        packet_done;
  logic        sync_reject;
} cursor_beat_t;

class cursor_scoreboard;
  // mirror of the block's registers and state
  logic [13:0]      screen_w;
  logic [13:0]      screen_h;
  pmct_pkg::phase_t phase;
  logic [7:0]       status_byte;
  logic [13:0]      pos_x;
  logic [13:0]      pos_y;
  logic [31:0]      accum_x;
  logic [31:0]      accum_y;

  cursor_beat_t expected_beats[$];
  int mismatches;
  int orphan_beats;
  int beats_checked;
  int packets;
  int rejects;
  int ignored;

  function new();
    screen_w    = pmct_pkg::WidthReset;
    screen_h    = pmct_pkg::HeightReset;
    phase       = pmct_pkg::PH_STATUS;
    status_byte = 8'h00;
    accum_x     = 32'd0;
    accum_y     = 32'd0;
    mismatches  = 0;
    orphan_beats = 0;
    beats_checked = 0;
    packets = 0;
    rejects = 0;
    ignored = 0;
    recentre();
  endfunction

  function void recentre();
    pos_x = screen_w >> 1;
    pos_y = screen_h >> 1;
  endfunction

  function void write_size(logic idx, logic [31:0] value);
    if (idx == pmct_pkg::RegWidth) screen_w = value[13:0];
    else screen_h = value[13:0];
    recentre();
  endfunction

  // zero size behaves as one, so the coordinate pins to 0
  function logic [13:0] move_clamped(logic [13:0] pos, int step, logic [13:0] size);
    int lim;
    int v;
    lim = ((size == 14'd0) ? 1 : int'(size)) - 1;
    v = int'(pos) + step;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return 14'(v);
  endfunction

  function int delta9(logic [7:0] b, logic negative);
    return negative ? int'(b) - 256 : int'(b);
  endfunction

  function void note_byte(logic [7:0] b, logic aux);
    cursor_beat_t e;
    int d;
    e.packet_done = 1'b0;
    e.sync_reject = 1'b0;
    if (!aux) begin
      ignored++;
    end else begin
      case (phase)
        pmct_pkg::PH_DX: begin
          d = delta9(b, status_byte[pmct_pkg::XSignBit]);
          pos_x = move_clamped(pos_x, d, screen_w);
          accum_x = accum_x + 32'(d);
          phase = pmct_pkg::PH_DY;
        end
        pmct_pkg::PH_DY: begin
          d = delta9(b, status_byte[pmct_pkg::YSignBit]);
          pos_y = move_clamped(pos_y, -d, screen_h);
          accum_y = accum_y - 32'(d);
          phase = pmct_pkg::PH_STATUS;
          e.packet_done = 1'b1;
          packets++;
        end
        default: begin
          if (b[pmct_pkg::SyncBit] && !b[pmct_pkg::XOvfBit] && !b[pmct_pkg::YOvfBit]) begin
            status_byte = b;
            phase = pmct_pkg::PH_DX;
          end else begin
            phase = pmct_pkg::PH_STATUS;
            e.sync_reject = 1'b1;
            rejects++;
          end
        end
      endcase
    end
    e.cursor_x = pos_x;
    e.cursor_y = pos_y;
    e.total_x  = accum_x;
    e.total_y  = accum_y;
    e.buttons  = status_byte[2:0];
    expected_beats.push_back(e);
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result beat %0d, %s: expected %0h, got %0h",
                 beats_checked, name, exp_v, act_v);
    end
  endfunction

  function void check_beat(logic [95:0] data, logic [1:0] user);
    cursor_beat_t e;
    if (expected_beats.size() == 0) begin
      orphan_beats++;
      if (orphan_beats + mismatches <= 10)
        $display("result beat with nothing expected: data %0h user %0h", data, user);
      return;
    end
    e = expected_beats.pop_front();
    compare_field("cursor_x", 32'(e.cursor_x), 32'(data[13:0]));
    compare_field("cursor_y", 32'(e.cursor_y), 32'(data[27:14]));
    compare_field("total_x", e.total_x, data[59:28]);
    compare_field("total_y", e.total_y, data[91:60]);
    compare_field("buttons", 32'(e.buttons), 32'(data[94:92]));
    compare_field("pad", 32'd0, 32'(data[95]));
    compare_field("packet_done", 32'(e.packet_done), 32'(user[0]));
    compare_field("sync_reject", 32'(e.sync_reject), 32'(user[1]));
    beats_checked++;
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction
endclass

module ps2_mouse_packet_cursor_tracker_core_test;
  import pmct_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int StallCycles   = 120;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;    // [7:0] data_byte
  logic [0:0]             in_tuser = 1'b0;     // [0] from_aux_port
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [13:0] cursor_x, [27:14] cursor_y, [59:28] total_x, [91:60] total_y,
  // [94:92] buttons, [95] zero
  logic [95:0]            out_tdata;
  logic [1:0]             out_tuser;           // [0] packet_done, [1] sync_reject
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CfgAddrBits-1:0] cfg_paddr = '0;
  logic [CfgDataBits-1:0] cfg_pwdata = '0;
  logic [CfgDataBits-1:0] cfg_prdata;
  logic                   cfg_pready;

  cursor_scoreboard sb = new();

  int send_idle = 0;
  int recv_idle = 0;
  int stall_reqs = 0;
  int stall_served = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int size_writes = 0;

  ps2_mouse_packet_cursor_tracker_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // result side: check accepted beats, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser);
    if (stall_served != stall_reqs) begin
      stall_served = stall_reqs;
      stall_left = StallCycles;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               WatchdogLimit, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic aux);
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= aux;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, aux);
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // let the pipeline settle before touching registers
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic idx, logic [13:0] size);
    logic [31:0] wdata;
    // upper bits are junk the block must drop
    wdata = {18'($urandom), size};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAddrBits'({idx, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_size(idx, wdata);
    size_writes++;
  endtask

  // mostly well-formed packets with random content, some noise and stray port bytes
  task automatic run_traffic(int n_aux, bit with_stall);
    int sent;
    logic [7:0] status;
    sent = 0;
    while (sent < n_aux) begin
      if (with_stall && sent >= n_aux / 2) begin
        with_stall = 1'b0;
        stall_reqs++;
      end
      if ($urandom_range(0, 99) < 15) begin
        send_byte(8'($urandom), 1'b1);
        sent++;
      end else begin
        status = {2'b00, 2'($urandom), 1'b1, 3'($urandom)};
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 99) < 6) send_byte(8'($urandom), 1'b0);
          send_byte((k == 0) ? status : 8'($urandom), 1'b1);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(logic [13:0] w, logic [13:0] h, int s_idle, int r_idle,
                           int n_aux, bit with_stall);
    drain_results();
    write_size(RegWidth, w);
    write_size(RegHeight, h);
    send_idle = s_idle;
    recv_idle = r_idle;
    run_traffic(n_aux, with_stall);
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    logic       directed_aux[$];
    directed_bytes = '{8'hFF, 8'h00, 8'h48, 8'h88, 8'hC8, 8'h0F, 8'hFF, 8'h55, 8'hFF,
                       8'h38, 8'h00, 8'h00, 8'h18, 8'hFF, 8'h80, 8'h28, 8'h01, 8'hFF,
                       8'hF7, 8'h08, 8'h7F, 8'h00};
    directed_aux   = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                       1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                       1'b1, 1'b1, 1'b1, 1'b1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray port bytes, every reject reason, sign and magnitude extremes
    send_idle = 0;
    recv_idle = 0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i], directed_aux[i]);

    run_phase(14'd16383, 14'd16383, 25, 68, 250, 1'b0);
    run_phase(14'd0, 14'd1, 25, 68, 150, 1'b1);
    run_phase(14'd7, 14'd5, 25, 68, 200, 1'b0);
    run_phase(14'($urandom_range(1, 64)), 14'($urandom_range(1, 64)), 68, 25, 250, 1'b1);
    run_phase(14'd1, 14'd16383, 68, 25, 150, 1'b0);
    run_phase(14'($urandom_range(1, 16383)), 14'($urandom_range(1, 16383)), 0, 0, 250,
              1'b0);
    run_phase(14'd300, 14'd200, 0, 0, 300, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    $display("run covered %0d bytes (%0d stray port), %0d packets, %0d sync rejects",
             items_sent, sb.ignored, sb.packets, sb.rejects);
    $display("%0d result beats checked across %0d size writes, %0d long output stalls",
             sb.beats_checked, size_writes, stall_reqs);
    if (sb.mismatches == 0 && sb.orphan_beats == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d unexpected beats, %0d beats missing",
               sb.mismatches, sb.orphan_beats, sb.pending());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/pmct_pkg.sv
design/pmct_front.sv
design/pmct_queue.sv
design/pmct_back.sv
design/ps2_mouse_packet_cursor_tracker_core.sv
verif/ps2_mouse_packet_cursor_tracker_core_test.sv
